// ----- hw/rtl/text_screen_diff_buffer_macros.svh -----
// assertion macros for the text screen diff buffer checker
`ifndef TEXT_SCREEN_DIFF_BUFFER_MACROS_SVH
`define TEXT_SCREEN_DIFF_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TSDB_ASSERT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsdb assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define TSDB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsdb assertion failed");

`endif

// ----- hw/rtl/tsdb_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the text screen diff buffer
package tsdb_pkg;

    localparam logic [7:0] BLANK_CH    = 8'h20;
    localparam int         CELL_AW     = 16;
    localparam int         COORD_W     = 8;
    localparam int         QUEUE_DEPTH = 4;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd24;

    localparam logic [1:0] KIND_PUT_XY  = 2'd0;
    localparam logic [1:0] KIND_PUT_CUR = 2'd1;
    localparam logic [1:0] KIND_SCAN    = 2'd2;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_SCAN = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CELL_AW-1:0] addr;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         ch;
        logic               last;
    } cmd_t;

endpackage

// ----- hw/rtl/text_screen_diff_buffer.sv -----
`timescale 1ns / 1ps
// top level of the double-buffered text screen with per-cell dirty update
// a scan beat passes through a queue entry, the store read registers and the result register
// throughput: one beat per cycle once the clearing pass is over, puts and scans alike, set by one store access per beat
// reset: cursor and scan position go to zero, width 80 and height 24
// reset: a clearing pass over all MAX_COLS*MAX_ROWS cells (8192 by default) holds busy high
// the receiver cannot stall: each result strobe lasts exactly one cycle
module text_screen_diff_buffer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [11:0] col,
    input  logic signed [11:0] row,
    input  logic [7:0]         ch,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               result_valid,
    output logic [6:0]         out_col,
    output logic [5:0]         out_row,
    output logic [7:0]         out_ch,
    output logic               changed,
    output logic               frame_done
);
    import tsdb_pkg::*;

    logic push, pop, q_empty, q_full, clearing;
    cmd_t front_cmd, head_cmd;

    assign busy = clearing || q_full;

    tsdb_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .col       (col),
        .row       (row),
        .ch        (ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (front_cmd)
    );

    tsdb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .empty  (q_empty),
        .full   (q_full)
    );

    tsdb_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head         (head_cmd),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_ch       (out_ch),
        .changed      (changed),
        .frame_done   (frame_done)
    );

endmodule

// ----- hw/rtl/tsdb_front.sv -----
`timescale 1ns / 1ps
// front end: config registers, cursor, scan position, clipping and command build
module tsdb_front #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [11:0] col,
    input  logic signed [11:0] row,
    input  logic [7:0]         ch,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               push,
    output tsdb_pkg::cmd_t     cmd
);
    import tsdb_pkg::*;

    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int NRW = $clog2(MAX_ROWS + 1);

    logic [7:0]         cols_in_use_reg;
    logic [6:0]         rows_in_use_reg;
    logic [11:0]        cursor_col_reg, cursor_col_next;
    logic [11:0]        cursor_row_reg, cursor_row_next;
    logic [NCW-1:0]     scan_col_reg, scan_col_next;
    logic [NRW-1:0]     scan_row_reg, scan_row_next;
    logic [8:0]         cols_wide, rows_wide;
    logic [NCW-1:0]     eff_cols;
    logic [NRW-1:0]     eff_rows;
    logic               accept;
    logic [11:0]        put_c, put_r;
    logic               on_screen;
    logic [NCW-1:0]     cur_c;
    logic [NRW-1:0]     cur_r;
    logic               last_col, last_row;
    logic [COORD_W-1:0] sel_c, sel_r;

    assign accept    = start && !busy;
    assign cols_wide = {1'b0, cols_in_use_reg};
    assign rows_wide = {2'b00, rows_in_use_reg};

    // zero means one, above the maximum means the maximum
    assign eff_cols = (cols_in_use_reg == '0) ? NCW'(1) :
                      (cols_wide > 9'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_wide);
    assign eff_rows = (rows_in_use_reg == '0) ? NRW'(1) :
                      (rows_wide > 9'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_wide);

    assign put_c = (kind == KIND_PUT_XY) ? col : cursor_col_reg;
    assign put_r = (kind == KIND_PUT_XY) ? row : cursor_row_reg;

    assign on_screen = !put_c[11] && !put_r[11] &&
                       (put_c < 12'(eff_cols)) && (put_r < 12'(eff_rows));

    // restart the scan if the screen shrank under it
    always_comb
    begin
        cur_c = scan_col_reg;
        cur_r = scan_row_reg;
        if (scan_col_reg >= eff_cols || scan_row_reg >= eff_rows)
        begin
            cur_c = '0;
            cur_r = '0;
        end
        last_col = (cur_c + NCW'(1)) == eff_cols;
        last_row = (cur_r + NRW'(1)) == eff_rows;
    end

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        push            = 1'b0;
        if (accept)
        begin
            unique case (kind)
                KIND_PUT_XY:
                begin
                    cursor_col_next = col + 12'd1;
                    cursor_row_next = row;
                    push            = on_screen;
                end
                KIND_PUT_CUR:
                begin
                    cursor_col_next = cursor_col_reg + 12'd1;
                    push            = on_screen;
                end
                KIND_SCAN:
                begin
                    push = 1'b1;
                    if (last_col && last_row)
                    begin
                        scan_col_next = '0;
                        scan_row_next = '0;
                    end
                    else if (last_col)
                    begin
                        scan_col_next = '0;
                        scan_row_next = cur_r + NRW'(1);
                    end
                    else
                    begin
                        scan_col_next = cur_c + NCW'(1);
                        scan_row_next = cur_r;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        sel_c    = (kind == KIND_SCAN) ? COORD_W'(cur_c) : put_c[COORD_W-1:0];
        sel_r    = (kind == KIND_SCAN) ? COORD_W'(cur_r) : put_r[COORD_W-1:0];
        cmd.op   = (kind == KIND_SCAN) ? OP_SCAN : OP_PUT;
        cmd.col  = sel_c;
        cmd.row  = sel_r;
        cmd.addr = CELL_AW'(int'(sel_r) * MAX_COLS + int'(sel_c));
        cmd.ch   = ch;
        cmd.last = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg <= COLS_RESET;
            rows_in_use_reg <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLS: cols_in_use_reg <= cfg_data;
                CFG_ROWS: rows_in_use_reg <= cfg_data[6:0];
                default:  cols_in_use_reg <= cols_in_use_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
        end
    end

endmodule

// ----- hw/rtl/tsdb_queue.sv -----
`timescale 1ns / 1ps
// short command queue between front and back
module tsdb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsdb_pkg::cmd_t wr_cmd,
    input  logic           pop,
    output tsdb_pkg::cmd_t rd_cmd,
    output logic           empty,
    output logic           full
);
    import tsdb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign rd_cmd = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/tsdb_back.sv -----
`timescale 1ns / 1ps
// back end: character stores, clearing pass, read-modify-write and result register
module tsdb_back #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tsdb_pkg::cmd_t head,
    output logic           pop,
    output logic           clearing,
    output logic           result_valid,
    output logic [6:0]     out_col,
    output logic [5:0]     out_row,
    output logic [7:0]     out_ch,
    output logic           changed,
    output logic           frame_done
);
    import tsdb_pkg::*;

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [7:0]    draw_mem  [CELLS];
    logic [7:0]    shown_mem [CELLS];

    logic          s2_valid_reg;
    cmd_t          s2_cmd_reg;
    logic [7:0]    rd_draw_reg, rd_shown_reg;

    logic          draw_we, shown_we;
    logic [AW-1:0] draw_wa, shown_wa;
    logic [7:0]    draw_wd, shown_wd;
    logic [AW-1:0] head_addr, s2_addr;
    logic          fwd_draw, fwd_shown;
    logic          scan_fire;

    logic          res_valid_reg, res_changed_reg, res_last_reg;
    logic [6:0]    res_col_reg;
    logic [5:0]    res_row_reg;
    logic [7:0]    res_ch_reg;

    assign head_addr = head.addr[AW-1:0];
    assign s2_addr   = s2_cmd_reg.addr[AW-1:0];
    assign clearing  = (state_reg == ST_CLEAR);
    assign pop       = (state_reg == ST_RUN) && !empty;
    assign scan_fire = s2_valid_reg && (s2_cmd_reg.op == OP_SCAN);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // write side of both stores
    always_comb
    begin
        draw_we  = 1'b0;
        draw_wa  = s2_addr;
        draw_wd  = BLANK_CH;
        shown_we = 1'b0;
        shown_wa = s2_addr;
        shown_wd = rd_draw_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                draw_we  = 1'b1;
                draw_wa  = clr_addr_reg;
                shown_we = 1'b1;
                shown_wa = clr_addr_reg;
                shown_wd = BLANK_CH;
            end
            ST_RUN:
            begin
                draw_we  = s2_valid_reg;
                draw_wd  = (s2_cmd_reg.op == OP_SCAN) ? BLANK_CH : s2_cmd_reg.ch;
                shown_we = scan_fire;
            end
            default:
            begin
                draw_we  = 1'b0;
                shown_we = 1'b0;
            end
        endcase
    end

    // bypass the write in flight to the same cell
    assign fwd_draw  = draw_we && (draw_wa == head_addr);
    assign fwd_shown = shown_we && (shown_wa == head_addr);

    always_ff @(posedge clk)
    begin
        if (draw_we)
        begin
            draw_mem[draw_wa] <= draw_wd;
        end
        rd_draw_reg <= fwd_draw ? draw_wd : draw_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (shown_we)
        begin
            shown_mem[shown_wa] <= shown_wd;
        end
        rd_shown_reg <= fwd_shown ? shown_wd : shown_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg  <= head;
        res_col_reg <= s2_cmd_reg.col[6:0];
        res_row_reg <= s2_cmd_reg.row[5:0];
        res_ch_reg  <= rd_draw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            s2_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_changed_reg <= 1'b0;
            res_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            s2_valid_reg    <= pop;
            res_valid_reg   <= scan_fire;
            res_changed_reg <= scan_fire && (rd_draw_reg != rd_shown_reg);
            res_last_reg    <= scan_fire && s2_cmd_reg.last;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_col      = res_col_reg;
    assign out_row      = res_row_reg;
    assign out_ch       = res_ch_reg;
    assign changed      = res_changed_reg;
    assign frame_done   = res_last_reg;

endmodule

// ----- hw/rtl/tsdb_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the text screen diff buffer and its bind
`include "text_screen_diff_buffer_macros.svh"

module tsdb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       result_valid,
    input logic       changed,
    input logic       frame_done
);
    import tsdb_pkg::*;

    // every result beat comes from a scan beat taken earlier
    `TSDB_ASSERT(result_from_scan, result_valid, $past(start && !busy && kind == KIND_SCAN, 3))
    // status flags only ride on a result beat
    `TSDB_ASSERT(flags_with_result, changed || frame_done, result_valid)
    // once the clearing pass is over the queue never fills
    `TSDB_ASSERT_NEXT(busy_stays_low, !busy, !busy)

endmodule

bind text_screen_diff_buffer tsdb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .result_valid (result_valid),
    .changed      (changed),
    .frame_done   (frame_done)
);
